### rtl/m4m_pkg.sv
// Package: shared constants and types for the 4x4 matrix multiplier.
package m4m_pkg;
   localparam int DIM       = 4;
   localparam int FRAC_BITS = 16;
   localparam int ELEMS     = DIM * DIM;
   localparam int IDX_W     = $clog2(ELEMS);
   localparam int K_W       = $clog2(DIM);
   localparam int CNT_W     = $clog2(2 * ELEMS + 1);
   localparam int ACC_W     = 64 + K_W + 1;
   localparam int DATA_W    = 32;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
endpackage

### rtl/mat4_multiply.sv
// Top level: 4x4 Q16.16 matrix multiplier built on two chains of shift cells.
//
//  channel | dir | ports                                   | accepted when
//  req     | in  | req_valid req_ready req_element_value    | valid && ready
//  rsp     | out | rsp_valid rsp_ready rsp_product_value,   | valid && ready
//          |     |   rsp_product_index rsp_last_element     |
//
// Loading accepts one request per cycle while req_ready is high, 32 in all.
// After the 32nd the block computes each product on one shared unit: it issues
// the DIM multiplies and lets the last one land in the accumulator, moves the
// product into the output register once that register is free, and then
// advances the index. req_ready is low while products are computed or wait.
// A stalled result holds in the output register. Synchronous reset clears
// the load count and control state; stored elements are not cleared.
module mat4_multiply (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [31:0] req_element_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_product_value,
   output logic [3:0]  rsp_product_index,
   output logic        rsp_last_element
);
   localparam int E = m4m_pkg::ELEMS;

   typedef enum logic [1:0] {LOAD, MAC, EMIT} state_type;

   state_type state_ff;
   logic [m4m_pkg::CNT_W-1:0] cnt_ff;
   logic [m4m_pkg::IDX_W-1:0] idx_ff;
   logic [m4m_pkg::K_W:0]     k_ff;
   logic [m4m_pkg::K_W-1:0]   ka;
   logic                      mac_clr_ff, mac_en_ff, mac_clr_in, mac_en_in;
   m4m_pkg::data_type         lchain [E+1];
   m4m_pkg::data_type         rchain [E+1];
   m4m_pkg::data_type         res_ff, mac_res, a_sel, b_sel;
   logic [3:0]                ridx_ff;
   logic                      rlast_ff, rvld_ff;
   logic                      accept, lshift, rshift;
   logic                      res_load;
   logic [m4m_pkg::IDX_W-1:0] row, col;

   assign req_ready = (state_ff == LOAD);
   assign accept    = req_valid && req_ready;
   assign lshift    = accept && (cnt_ff < m4m_pkg::CNT_W'(E));
   assign rshift    = accept && !(cnt_ff < m4m_pkg::CNT_W'(E));

   // left and right chains: each accepted element enters at the tail
   assign lchain[E] = req_element_value;
   assign rchain[E] = req_element_value;
   for (genvar i = 0; i < E; i++) begin : g_cells
      m4m_cell u_l (.clock(clock), .shift(lshift), .din(lchain[i+1]), .dout(lchain[i]));
      m4m_cell u_r (.clock(clock), .shift(rshift), .din(rchain[i+1]), .dout(rchain[i]));
   end

   // after loading, element j of a matrix sits in cell j
   assign row = idx_ff / m4m_pkg::IDX_W'(m4m_pkg::DIM);
   assign col = idx_ff % m4m_pkg::IDX_W'(m4m_pkg::DIM);
   assign ka  = k_ff[m4m_pkg::K_W-1:0];
   assign a_sel = lchain[m4m_pkg::IDX_W'(row * m4m_pkg::IDX_W'(m4m_pkg::DIM)) + m4m_pkg::IDX_W'(ka)];
   assign b_sel = rchain[m4m_pkg::IDX_W'(m4m_pkg::IDX_W'(ka) * m4m_pkg::IDX_W'(m4m_pkg::DIM)) + col];

   m4m_mac u_mac (
      .clock(clock), .clear(mac_clr_ff), .enable(mac_en_ff),
      .a(a_sel), .b(b_sel), .result(mac_res)
   );

   // product register feeds the accumulator in the cycle after the multiply is issued
   assign mac_en_in  = (state_ff == MAC) && (k_ff < (m4m_pkg::K_W+1)'(m4m_pkg::DIM));
   assign mac_clr_in = (state_ff == MAC) && (k_ff == '0);

   // finished product moves to the output register once that register is free
   assign res_load = (state_ff == MAC) && (k_ff == (m4m_pkg::K_W+1)'(m4m_pkg::DIM + 1))
                     && (!rvld_ff || rsp_ready);

   always_ff @(posedge clock) begin
      mac_clr_ff <= mac_clr_in;
      if (reset) begin
         state_ff <= LOAD;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         k_ff     <= '0;
         rvld_ff  <= 1'b0;
         mac_en_ff <= 1'b0;
      end else begin
         mac_en_ff <= mac_en_in;
         if (rvld_ff && rsp_ready && !res_load) begin
            rvld_ff <= 1'b0;
         end
         case (state_ff)
            LOAD: begin
               if (accept) begin
                  if (cnt_ff == m4m_pkg::CNT_W'(2 * E - 1)) begin
                     cnt_ff   <= '0;
                     idx_ff   <= '0;
                     k_ff     <= '0;
                     state_ff <= MAC;
                  end else begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end
               end
            end
            MAC: begin
               // wait for the last product to land in the accumulator
               if (k_ff == (m4m_pkg::K_W+1)'(m4m_pkg::DIM + 1)) begin
                  if (res_load) begin
                     res_ff   <= mac_res;
                     ridx_ff  <= 4'(idx_ff);
                     rlast_ff <= (idx_ff == m4m_pkg::IDX_W'(E - 1));
                     rvld_ff  <= 1'b1;
                     state_ff <= EMIT;
                  end
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            EMIT: begin
               k_ff <= '0;
               if (idx_ff == m4m_pkg::IDX_W'(E - 1)) begin
                  state_ff <= LOAD;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= MAC;
               end
            end
            default: state_ff <= LOAD;
         endcase
      end
   end

   assign rsp_valid         = rvld_ff;
   assign rsp_product_value = res_ff;
   assign rsp_product_index = ridx_ff;
   assign rsp_last_element  = rlast_ff;
endmodule

### rtl/m4m_cell.sv
// Shift cell: one stored matrix element, passed to the neighbor on shift.
module m4m_cell (
   input  logic              clock,
   input  logic              shift,
   input  m4m_pkg::data_type din,
   output m4m_pkg::data_type dout
);
   m4m_pkg::data_type val_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         val_ff <= din;
      end
   end

   assign dout = val_ff;
endmodule

### rtl/m4m_mac.sv
// Multiply-accumulate unit with shift and saturation of the finished sum.
module m4m_mac (
   input  logic              clock,
   input  logic              clear,
   input  logic              enable,
   input  m4m_pkg::data_type a,
   input  m4m_pkg::data_type b,
   output m4m_pkg::data_type result
);
   logic signed [63:0] prod_ff;
   m4m_pkg::acc_type   acc_ff;
   m4m_pkg::acc_type   shifted;
   m4m_pkg::acc_type   acc_in;

   always_comb begin
      acc_in = (clear ? '0 : acc_ff) + m4m_pkg::acc_type'(prod_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(a) * 64'(b);
      if (enable) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      shifted = acc_ff >>> m4m_pkg::FRAC_BITS;
      if (shifted > m4m_pkg::acc_type'(32'sh7fffffff)) begin
         result = 32'sh7fffffff;
      end else if (shifted < -m4m_pkg::acc_type'(33'sh080000000)) begin
         result = 32'sh80000000;
      end else begin
         result = shifted[m4m_pkg::DATA_W-1:0];
      end
   end
endmodule

### tb/tb.sv
// Testbench for the 4x4 Q16.16 matrix multiplier: random requests, predicted products, checks.
module tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic signed [31:0] req_element_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [31:0] rsp_product_value;
   logic [3:0]  rsp_product_index;
   logic        rsp_last_element;

   typedef struct {
      logic signed [31:0] value;
      logic [3:0]         index;
      logic               last;
   } product_type;

   mat4_multiply dut (.*);

   // clock: period 2
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic signed [31:0] pending_elems[$];
   product_type        expected_products[$];
   logic signed [31:0] left_mat[m4m_pkg::ELEMS];
   logic signed [31:0] right_mat[m4m_pkg::ELEMS];
   int  load_pos = 0;
   int  errors = 0;
   int  sent_cnt = 0;
   int  prod_cnt = 0;
   int  sat_cnt = 0;
   int  idle_cycles = 0;
   bit  stim_done = 0;
   bit  quiet_phase = 0;
   bit  req_taken = 0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   localparam int WATCHDOG = 4000;

   // Sum of left row times right column, floor shift by the fraction bits, saturate.
   function automatic logic signed [31:0] dot_product(int row, int col);
      logic signed [127:0] acc;
      logic signed [127:0] shifted;
      acc = '0;
      for (int k = 0; k < m4m_pkg::DIM; k++)
         acc += 128'(left_mat[row*m4m_pkg::DIM+k]) * 128'(right_mat[k*m4m_pkg::DIM+col]);
      shifted = acc >>> m4m_pkg::FRAC_BITS;
      if (shifted > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (shifted < -128'sh80000000) return 32'sh80000000;
      return shifted[31:0];
   endfunction

   // Store one accepted element; on the last right element queue all sixteen products.
   task automatic predict_products(logic signed [31:0] v);
      product_type p;
      if (load_pos < m4m_pkg::ELEMS) left_mat[load_pos] = v;
      else right_mat[load_pos-m4m_pkg::ELEMS] = v;
      load_pos++;
      if (load_pos == 2*m4m_pkg::ELEMS) begin
         for (int i = 0; i < m4m_pkg::ELEMS; i++) begin
            p.value = dot_product(i / m4m_pkg::DIM, i % m4m_pkg::DIM);
            p.index = 4'(i);
            p.last  = (i == m4m_pkg::ELEMS-1);
            if (p.value == 32'sh7FFFFFFF || p.value == 32'sh80000000) sat_cnt++;
            expected_products.push_back(p);
         end
         load_pos = 0;
      end
   endtask

   // Driver: advance on acceptance, hold payload while stalled, drop valid in gap bursts.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // hold the request
         end else begin
            if (req_taken) begin
               void'(pending_elems.pop_front());
               sent_cnt++;
               req_taken = 1'b0;
            end
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_elems.size() > 0) begin
               if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                  req_gap = $urandom_range(1, 14);
                  req_valid <= 1'b0;
               end else begin
                  req_valid <= 1'b1;
                  req_element_value <= pending_elems[0];
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(1, 14);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: predict on accepted requests, check accepted results, run the watchdog.
   always @(posedge clock) begin
      product_type e;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_products(req_element_value);
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            prod_cnt++;
            if (expected_products.size() == 0) begin
               $display("%0t: unexpected product value=%h index=%0d last=%b", $time,
                        rsp_product_value, rsp_product_index, rsp_last_element);
               errors++;
            end else begin
               e = expected_products.pop_front();
               if (e.value !== rsp_product_value) begin
                  $display("%0t: value mismatch expected %h actual %h", $time,
                           e.value, rsp_product_value);
                  errors++;
               end
               if (e.index !== rsp_product_index) begin
                  $display("%0t: index mismatch expected %0d actual %0d", $time,
                           e.index, rsp_product_index);
                  errors++;
               end
               if (e.last !== rsp_last_element) begin
                  $display("%0t: last mismatch expected %b actual %b", $time,
                           e.last, rsp_last_element);
                  errors++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("Watchdog: no progress, %0d products outstanding",
                     expected_products.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Push one matrix pair; kind selects the content style.
   task automatic queue_pair(int kind);
      logic signed [31:0] v;
      for (int i = 0; i < 2*m4m_pkg::ELEMS; i++) begin
         case (kind)
            0: v = $urandom();
            1: v = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
            2: v = ($urandom_range(0, 1)) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: v = $signed($urandom_range(0, 32'h7FFFFF)) - 32'sh400000;
         endcase
         pending_elems.push_back(v);
      end
   endtask

   initial begin
      // directed: identity times counting values, then extremes to force saturation
      for (int i = 0; i < m4m_pkg::ELEMS; i++)
         pending_elems.push_back((i / m4m_pkg::DIM == i % m4m_pkg::DIM) ? 32'sh10000 : 32'sh0);
      for (int i = 0; i < m4m_pkg::ELEMS; i++)
         pending_elems.push_back(32'(i - 8) <<< 16);
      for (int i = 0; i < 2*m4m_pkg::ELEMS; i++)
         pending_elems.push_back((i % 3 == 0) ? 32'sh80000000 :
                                 (i % 3 == 1) ? 32'sh7FFFFFFF : -32'sh1);
      // random: eight matrix pairs, about 320 requests with the directed part
      for (int n = 0; n < 8; n++) queue_pair(n % 4);
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      while (pending_elems.size() > 64) @(posedge clock);
      quiet_phase = 1;
      while (pending_elems.size() > 0 || expected_products.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Covered %0d requests, %0d products checked, %0d saturated.",
               sent_cnt, prod_cnt, sat_cnt);
      if (errors == 0 && expected_products.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
